// ----- hdl/hgpc_pkg.sv -----
`timescale 1ns / 1ps

package hgpc_pkg;

   // request payload
   typedef struct packed {
      logic [7:0] pixel_index;
      logic [9:0] hue;
      logic [7:0] saturation;
      logic [7:0] value;
   } req_type;

   // result payload, stored order green, red, blue
   typedef struct packed {
      logic [7:0] pixel_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic [7:0] blue_out;
   } rsp_type;

   // hue sectors, 60 degrees each
   localparam logic [2:0] SEC_RED_TO_YELLOW    = 3'd0;
   localparam logic [2:0] SEC_YELLOW_TO_GREEN  = 3'd1;
   localparam logic [2:0] SEC_GREEN_TO_CYAN    = 3'd2;
   localparam logic [2:0] SEC_CYAN_TO_BLUE     = 3'd3;
   localparam logic [2:0] SEC_BLUE_TO_MAGENTA  = 3'd4;
   localparam logic [2:0] SEC_MAGENTA_TO_RED   = 3'd5;

   localparam logic [9:0] BRIGHTNESS_RESET = 10'd64;
   localparam logic [7:0] CHANNEL_MAX      = 8'd254;

   // exact division constants: estimate by reciprocal, then one correction
   localparam logic [7:0]  DIV_P        = 8'd255;
   localparam logic [16:0] RECIP_P      = 17'd65793;   // floor(2^24 / 255)
   localparam int          RECIP_P_SHFT = 24;
   localparam logic [13:0] DIV_QT       = 14'd15300;
   localparam logic [18:0] RECIP_QT     = 19'd280716;  // floor(2^32 / 15300)
   localparam int          RECIP_QT_SHFT = 32;

   // hue stage bundle
   typedef struct packed {
      logic       valid;
      logic [7:0] pix;
      logic [7:0] sat;
      logic [7:0] val;
      logic [2:0] sector;
      logic [5:0] rem;
   } hue_stage_type;

   // channel stage bundle
   typedef struct packed {
      logic       valid;
      logic [7:0] pix;
      logic       grey;
      logic [2:0] sector;
      logic [7:0] val;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
   } pqt_stage_type;

   // gamma 2.2 table: largest y with y^5 * 255^6 <= x^11
   typedef logic [255:0][7:0] gamma_rom_type;

   function automatic logic gamma_ok(input int unsigned x, input int unsigned y);
      logic [95:0] lhs;
      logic [95:0] rhs;
      lhs = 96'd1;
      rhs = 96'd1;
      for (int i = 0; i < 5; i++) lhs = lhs * 96'(y);
      for (int i = 0; i < 6; i++) lhs = lhs * 96'd255;
      for (int i = 0; i < 11; i++) rhs = rhs * 96'(x);
      return (lhs <= rhs);
   endfunction

   function automatic gamma_rom_type build_gamma();
      gamma_rom_type rom;
      int unsigned   y;
      rom = '0;
      y   = 0;
      for (int unsigned x = 0; x < 256; x++) begin
         while ((y < 255) && gamma_ok(x, y + 1)) y++;
         rom[x] = 8'(y);
      end
      return rom;
   endfunction

   localparam gamma_rom_type GAMMA_ROM = build_gamma();

endpackage

// ----- hdl/hgpc_csr.sv -----
`timescale 1ns / 1ps

module hgpc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [9:0]  brightness
);

   logic [9:0] brightness_ff;
   logic [9:0] brightness_in;
   logic       wr_en;

   // single register, every address in range decodes to it
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      brightness_in = brightness_ff;
      if (wr_en && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00)) begin
         brightness_in = pwdata[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= hgpc_pkg::BRIGHTNESS_RESET;
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   assign prdata     = {22'd0, brightness_ff};
   assign brightness = brightness_ff;

endmodule

// ----- hdl/hgpc_hue.sv -----
`timescale 1ns / 1ps

module hgpc_hue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  hgpc_pkg::req_type       in_req,
   output hgpc_pkg::hue_stage_type out_stage
);

   typedef struct packed {
      logic       valid;
      logic [7:0] pix;
      logic [8:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } hue_mod_type;

   hue_mod_type             mod_ff;
   hue_mod_type             mod_in;
   hgpc_pkg::hue_stage_type sec_ff;
   hgpc_pkg::hue_stage_type sec_in;
   logic [8:0]              base;

   // stage 1: hue modulo 360 (input is below 1080)
   always_comb begin
      mod_in.valid = in_valid;
      mod_in.pix   = in_req.pixel_index;
      mod_in.sat   = in_req.saturation;
      mod_in.val   = in_req.value;
      if (in_req.hue >= 10'd720) begin
         mod_in.hue = 9'(in_req.hue - 10'd720);
      end else if (in_req.hue >= 10'd360) begin
         mod_in.hue = 9'(in_req.hue - 10'd360);
      end else begin
         mod_in.hue = in_req.hue[8:0];
      end
   end

   // stage 2: sector and remainder
   always_comb begin
      if (mod_ff.hue < 9'd60) begin
         sec_in.sector = hgpc_pkg::SEC_RED_TO_YELLOW;
         base          = 9'd0;
      end else if (mod_ff.hue < 9'd120) begin
         sec_in.sector = hgpc_pkg::SEC_YELLOW_TO_GREEN;
         base          = 9'd60;
      end else if (mod_ff.hue < 9'd180) begin
         sec_in.sector = hgpc_pkg::SEC_GREEN_TO_CYAN;
         base          = 9'd120;
      end else if (mod_ff.hue < 9'd240) begin
         sec_in.sector = hgpc_pkg::SEC_CYAN_TO_BLUE;
         base          = 9'd180;
      end else if (mod_ff.hue < 9'd300) begin
         sec_in.sector = hgpc_pkg::SEC_BLUE_TO_MAGENTA;
         base          = 9'd240;
      end else begin
         sec_in.sector = hgpc_pkg::SEC_MAGENTA_TO_RED;
         base          = 9'd300;
      end
      sec_in.rem   = 6'(mod_ff.hue - base);
      sec_in.valid = mod_ff.valid;
      sec_in.pix   = mod_ff.pix;
      sec_in.sat   = mod_ff.sat;
      sec_in.val   = mod_ff.val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff.valid <= 1'b0;
         sec_ff.valid <= 1'b0;
      end else begin
         mod_ff.valid <= mod_in.valid;
         sec_ff.valid <= sec_in.valid;
      end
      mod_ff.pix    <= mod_in.pix;
      mod_ff.hue    <= mod_in.hue;
      mod_ff.sat    <= mod_in.sat;
      mod_ff.val    <= mod_in.val;
      sec_ff.pix    <= sec_in.pix;
      sec_ff.sat    <= sec_in.sat;
      sec_ff.val    <= sec_in.val;
      sec_ff.sector <= sec_in.sector;
      sec_ff.rem    <= sec_in.rem;
   end

   assign out_stage = sec_ff;

endmodule

// ----- hdl/hgpc_chroma.sv -----
`timescale 1ns / 1ps

module hgpc_chroma (
   input  logic                    clock,
   input  logic                    reset,
   input  hgpc_pkg::hue_stage_type in_stage,
   output hgpc_pkg::pqt_stage_type out_stage
);

   typedef struct packed {
      logic       valid;
      logic [7:0] pix;
      logic       grey;
      logic [2:0] sector;
      logic [7:0] val;
      logic [7:0] pf;
      logic [13:0] sr;
      logic [13:0] st;
   } prod_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  pix;
      logic        grey;
      logic [2:0]  sector;
      logic [7:0]  val;
      logic [15:0] pn;
      logic [21:0] qn;
      logic [21:0] tn;
   } num_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  pix;
      logic        grey;
      logic [2:0]  sector;
      logic [7:0]  val;
      logic [15:0] pn;
      logic [21:0] qn;
      logic [21:0] tn;
      logic [7:0]  pe;
      logic [7:0]  qe;
      logic [7:0]  te;
   } est_type;

   prod_type                c1_ff, c1_in;
   num_type                 c2_ff, c2_in;
   est_type                 c3_ff, c3_in;
   hgpc_pkg::pqt_stage_type c4_ff, c4_in;

   logic [32:0] p_prod;
   logic [40:0] q_prod;
   logic [40:0] t_prod;
   logic [15:0] p_rem;
   logic [21:0] q_rem;
   logic [21:0] t_rem;

   // stage 1: saturation products
   always_comb begin
      c1_in.valid  = in_stage.valid;
      c1_in.pix    = in_stage.pix;
      c1_in.grey   = (in_stage.sat == 8'd0);
      c1_in.sector = in_stage.sector;
      c1_in.val    = in_stage.val;
      c1_in.pf     = 8'd255 - in_stage.sat;
      c1_in.sr     = 14'(in_stage.sat) * 14'(in_stage.rem);
      c1_in.st     = 14'(in_stage.sat) * 14'(7'd60 - 7'(in_stage.rem));
   end

   // stage 2: numerators scaled by value
   always_comb begin
      c2_in.valid  = c1_ff.valid;
      c2_in.pix    = c1_ff.pix;
      c2_in.grey   = c1_ff.grey;
      c2_in.sector = c1_ff.sector;
      c2_in.val    = c1_ff.val;
      c2_in.pn     = 16'(c1_ff.val) * 16'(c1_ff.pf);
      c2_in.qn     = 22'(c1_ff.val) * 22'(hgpc_pkg::DIV_QT - c1_ff.sr);
      c2_in.tn     = 22'(c1_ff.val) * 22'(hgpc_pkg::DIV_QT - c1_ff.st);
   end

   // stage 3: reciprocal estimates, low by at most one
   always_comb begin
      p_prod       = 33'(c2_ff.pn) * 33'(hgpc_pkg::RECIP_P);
      q_prod       = 41'(c2_ff.qn) * 41'(hgpc_pkg::RECIP_QT);
      t_prod       = 41'(c2_ff.tn) * 41'(hgpc_pkg::RECIP_QT);
      c3_in.valid  = c2_ff.valid;
      c3_in.pix    = c2_ff.pix;
      c3_in.grey   = c2_ff.grey;
      c3_in.sector = c2_ff.sector;
      c3_in.val    = c2_ff.val;
      c3_in.pn     = c2_ff.pn;
      c3_in.qn     = c2_ff.qn;
      c3_in.tn     = c2_ff.tn;
      c3_in.pe     = 8'(p_prod >> hgpc_pkg::RECIP_P_SHFT);
      c3_in.qe     = 8'(q_prod >> hgpc_pkg::RECIP_QT_SHFT);
      c3_in.te     = 8'(t_prod >> hgpc_pkg::RECIP_QT_SHFT);
   end

   // stage 4: remainder check and correction
   always_comb begin
      p_rem = c3_ff.pn - 16'(c3_ff.pe) * 16'(hgpc_pkg::DIV_P);
      q_rem = c3_ff.qn - 22'(c3_ff.qe) * 22'(hgpc_pkg::DIV_QT);
      t_rem = c3_ff.tn - 22'(c3_ff.te) * 22'(hgpc_pkg::DIV_QT);
      c4_in.valid  = c3_ff.valid;
      c4_in.pix    = c3_ff.pix;
      c4_in.grey   = c3_ff.grey;
      c4_in.sector = c3_ff.sector;
      c4_in.val    = c3_ff.val;
      c4_in.p = (p_rem >= 16'(hgpc_pkg::DIV_P))  ? c3_ff.pe + 8'd1 : c3_ff.pe;
      c4_in.q = (q_rem >= 22'(hgpc_pkg::DIV_QT)) ? c3_ff.qe + 8'd1 : c3_ff.qe;
      c4_in.t = (t_rem >= 22'(hgpc_pkg::DIV_QT)) ? c3_ff.te + 8'd1 : c3_ff.te;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
         c4_ff.valid <= 1'b0;
      end else begin
         c1_ff.valid <= c1_in.valid;
         c2_ff.valid <= c2_in.valid;
         c3_ff.valid <= c3_in.valid;
         c4_ff.valid <= c4_in.valid;
      end
      c1_ff.pix    <= c1_in.pix;
      c1_ff.grey   <= c1_in.grey;
      c1_ff.sector <= c1_in.sector;
      c1_ff.val    <= c1_in.val;
      c1_ff.pf     <= c1_in.pf;
      c1_ff.sr     <= c1_in.sr;
      c1_ff.st     <= c1_in.st;
      c2_ff.pix    <= c2_in.pix;
      c2_ff.grey   <= c2_in.grey;
      c2_ff.sector <= c2_in.sector;
      c2_ff.val    <= c2_in.val;
      c2_ff.pn     <= c2_in.pn;
      c2_ff.qn     <= c2_in.qn;
      c2_ff.tn     <= c2_in.tn;
      c3_ff.pix    <= c3_in.pix;
      c3_ff.grey   <= c3_in.grey;
      c3_ff.sector <= c3_in.sector;
      c3_ff.val    <= c3_in.val;
      c3_ff.pn     <= c3_in.pn;
      c3_ff.qn     <= c3_in.qn;
      c3_ff.tn     <= c3_in.tn;
      c3_ff.pe     <= c3_in.pe;
      c3_ff.qe     <= c3_in.qe;
      c3_ff.te     <= c3_in.te;
      c4_ff.pix    <= c4_in.pix;
      c4_ff.grey   <= c4_in.grey;
      c4_ff.sector <= c4_in.sector;
      c4_ff.val    <= c4_in.val;
      c4_ff.p      <= c4_in.p;
      c4_ff.q      <= c4_in.q;
      c4_ff.t      <= c4_in.t;
   end

   assign out_stage = c4_ff;

endmodule

// ----- hdl/hgpc_out.sv -----
`timescale 1ns / 1ps

module hgpc_out (
   input  logic                    clock,
   input  logic                    reset,
   input  hgpc_pkg::pqt_stage_type in_stage,
   input  logic [9:0]              brightness,
   output logic                    out_valid,
   output hgpc_pkg::rsp_type       out_rsp
);

   typedef struct packed {
      logic       valid;
      logic [7:0] pix;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   rgb_type           rgb_ff, rgb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hgpc_pkg::rsp_type rsp_ff, rsp_in;
   logic [7:0]        r_raw, g_raw, b_raw;

   // scale one channel by brightness/256, saturate
   function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [9:0] k);
      logic [17:0] prod;
      logic [9:0]  sh;
      prod = 18'(c) * 18'(k);
      sh   = prod[17:8];
      return (sh > 10'(hgpc_pkg::CHANNEL_MAX)) ? hgpc_pkg::CHANNEL_MAX : sh[7:0];
   endfunction

   // stage 1: sector mapping and gamma, grey bypasses gamma
   always_comb begin
      case (in_stage.sector)
         hgpc_pkg::SEC_RED_TO_YELLOW: begin
            r_raw = in_stage.val; g_raw = in_stage.t;   b_raw = in_stage.p;
         end
         hgpc_pkg::SEC_YELLOW_TO_GREEN: begin
            r_raw = in_stage.q;   g_raw = in_stage.val; b_raw = in_stage.p;
         end
         hgpc_pkg::SEC_GREEN_TO_CYAN: begin
            r_raw = in_stage.p;   g_raw = in_stage.val; b_raw = in_stage.t;
         end
         hgpc_pkg::SEC_CYAN_TO_BLUE: begin
            r_raw = in_stage.p;   g_raw = in_stage.q;   b_raw = in_stage.val;
         end
         hgpc_pkg::SEC_BLUE_TO_MAGENTA: begin
            r_raw = in_stage.t;   g_raw = in_stage.p;   b_raw = in_stage.val;
         end
         default: begin
            r_raw = in_stage.val; g_raw = in_stage.p;   b_raw = in_stage.q;
         end
      endcase
      rgb_in.valid = in_stage.valid;
      rgb_in.pix   = in_stage.pix;
      if (in_stage.grey) begin
         rgb_in.r = in_stage.val;
         rgb_in.g = in_stage.val;
         rgb_in.b = in_stage.val;
      end else begin
         rgb_in.r = hgpc_pkg::GAMMA_ROM[r_raw];
         rgb_in.g = hgpc_pkg::GAMMA_ROM[g_raw];
         rgb_in.b = hgpc_pkg::GAMMA_ROM[b_raw];
      end
   end

   // stage 2: brightness scaling into the result register
   always_comb begin
      rsp_valid_in     = rgb_ff.valid;
      rsp_in.pixel_out = rgb_ff.pix;
      rsp_in.green_out = scale_ch(rgb_ff.g, brightness);
      rsp_in.red_out   = scale_ch(rgb_ff.r, brightness);
      rsp_in.blue_out  = scale_ch(rgb_ff.b, brightness);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rgb_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rgb_ff.valid <= rgb_in.valid;
         rsp_valid_ff <= rsp_valid_in;
      end
      rgb_ff.pix <= rgb_in.pix;
      rgb_ff.r   <= rgb_in.r;
      rgb_ff.g   <= rgb_in.g;
      rgb_ff.b   <= rgb_in.b;
      rsp_ff     <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- hdl/hsv_gamma_pixel_converter_top.sv -----
`timescale 1ns / 1ps
// Channel     Handshake                         Payload
// request     start / busy, taken start&!busy   req_data  (hgpc_pkg::req_type)
// result      rsp_strobe, one cycle per result  rsp_data  (hgpc_pkg::rsp_type)
// config      APB write psel&penable&pwrite     pwdata[9:0] brightness at every address
//
// One request per cycle; busy is always low.
// A result strobes once its request has passed 2 hue stages,
// 4 divide stages, the gamma stage and the scaling stage.
// Synchronous active-high reset empties the pipeline and sets brightness to 64.
// Results cannot be stalled; each is shown for exactly one cycle.

module hsv_gamma_pixel_converter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hgpc_pkg::req_type req_data,
   output logic              rsp_strobe,
   output hgpc_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   hgpc_pkg::hue_stage_type hue_stage;
   hgpc_pkg::pqt_stage_type pqt_stage;
   logic [9:0]              brightness;
   logic                    req_take;

   // pipeline never backs up
   assign busy     = 1'b0;
   assign req_take = start & ~busy;

   hgpc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .brightness (brightness)
   );

   hgpc_hue u_hue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_req    (req_data),
      .out_stage (hue_stage)
   );

   hgpc_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (hue_stage),
      .out_stage (pqt_stage)
   );

   hgpc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_stage   (pqt_stage),
      .brightness (brightness),
      .out_valid  (rsp_strobe),
      .out_rsp    (rsp_data)
   );

endmodule
